// ===== src/s5scan_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S5 scanner package
// Shared types and constants for the ACPI S5 sleep-type scanner.
// ----------------------------------------------------------------------------
package s5scan_pkg;

	typedef enum logic [1:0] {
		ST_PARSED  = 2'd0,
		ST_DEFAULT = 2'd1,
		ST_INVALID = 2'd2,
		ST_TRUNC   = 2'd3
	} status_t;

	localparam logic [7:0] PACKAGE_OP      = 8'h12;
	localparam logic [7:0] BYTE_PREFIX     = 8'h0A;
	localparam logic [7:0] WORD_PREFIX     = 8'h0B;
	localparam logic [7:0] SMALL_INT_LIMIT = 8'd64;
	localparam logic [7:0] NAME_UNDERSCORE = 8'h5F;
	localparam int         TYPE_SHIFT      = 10;
	localparam int         TYPE_BITS       = 16 - TYPE_SHIFT;
	localparam logic [2:0] DEFAULT_TYPE_RST = 3'd5;

	// characters of "_S5_"
	function automatic logic [7:0] name_char(input logic [1:0] pos);
		logic [7:0] ch;
		unique case (pos)
			2'd0: ch = 8'h5F;
			2'd1: ch = 8'h53;
			2'd2: ch = 8'h35;
			default: ch = 8'h5F;
		endcase
		return ch;
	endfunction

endpackage

// ===== src/s5scan_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S5 scanner channels
// Table byte, result and configuration request channels.
// ----------------------------------------------------------------------------
interface s5scan_tbl_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface s5scan_res_if;
	import s5scan_pkg::*;
	logic        valid;
	logic        ready;
	status_t     status;
	logic [15:0] sleep_type_a;
	logic [15:0] sleep_type_b;

	modport source (output valid, output status, output sleep_type_a,
		output sleep_type_b, input ready);
	modport sink (input valid, input status, input sleep_type_a,
		input sleep_type_b, output ready);
endinterface

interface s5scan_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] default_sleep_type;

	modport source (output valid, output default_sleep_type, input ready);
	modport sink (input valid, input default_sleep_type, output ready);
endinterface

// ===== src/acpi_s5_sleep_type_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ACPI S5 sleep-type scanner
// Streams one ACPI definition table, checks its checksum and extracts the
// two S5 sleep-type values from the _S5_ package.
// ----------------------------------------------------------------------------
// One table byte is taken every cycle unless a last byte waits in the input
// register; each byte is registered, then one byte-wise parse state machine
// updates the checksum, byte count and package decoder from it. Throughput is
// one byte per clock while no last byte waits. A table's single result passes
// the input register, then the result register. A waiting result does not
// stop the next table's bytes until the byte that carries last arrives.
module acpi_s5_sleep_type_scanner #(
	parameter int HEADER_BYTES = 36,
	parameter int COUNT_WIDTH  = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	s5scan_cfg_if.sink          cfg,
	s5scan_tbl_if.sink          tbl,
	s5scan_res_if.source        res
);
	import s5scan_pkg::*;

	typedef enum logic [3:0] {
		PH_NAME, PH_PKG, PH_LEAD, PH_SKIP, PH_COUNT, PH_A_START, PH_A_BYTE,
		PH_A_WLO, PH_A_WHI, PH_B_START, PH_B_BYTE, PH_DONE
	} phase_t;

	localparam logic [COUNT_WIDTH-1:0] CountMax = '1;
	localparam logic [COUNT_WIDTH-1:0] HdrCount = COUNT_WIDTH'(HEADER_BYTES);

	logic [2:0]             dflt_q;
	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   last_s1;
	logic [7:0]             sum_q,   sum_nx;
	logic [COUNT_WIDTH-1:0] cnt_q,   cnt_nx;
	phase_t                 phase_q, phase_nx;
	logic [1:0]             match_q, match_nx;
	logic [1:0]             len_q,   len_nx;
	logic [TYPE_BITS-1:0]   va_q,    va_nx;
	logic [TYPE_BITS-1:0]   vb_q,    vb_nx;
	logic [TYPE_BITS-1:0]   hold_q,  hold_nx;
	logic                   res_valid_q;
	status_t                res_status_q, status_nx;
	logic [15:0]            res_a_q, res_b_q, a_nx, b_nx;
	logic                   out_free, adv_s1, is_small;

	assign cfg.ready = 1'b1;
	assign out_free  = !res_valid_q || res.ready;
	assign adv_s1    = valid_s1 && (!last_s1 || out_free);
	assign tbl.ready = !valid_s1 || adv_s1;

	assign res.valid        = res_valid_q;
	assign res.status       = res_status_q;
	assign res.sleep_type_a = res_a_q;
	assign res.sleep_type_b = res_b_q;

	assign is_small = byte_s1 < SMALL_INT_LIMIT;

	always_comb begin
		sum_nx   = sum_q + byte_s1;
		cnt_nx   = (cnt_q == CountMax) ? cnt_q : cnt_q + 1'b1;
		phase_nx = phase_q;
		match_nx = match_q;
		len_nx   = len_q;
		va_nx    = va_q;
		vb_nx    = vb_q;
		hold_nx  = hold_q;
		unique case (phase_q)
			PH_NAME: begin
				if (cnt_q >= HdrCount) begin
					if (byte_s1 == name_char(match_q)) begin
						if (match_q == 2'd3) begin
							phase_nx = PH_PKG;
							match_nx = 2'd0;
						end else begin
							match_nx = match_q + 1'b1;
						end
					end else begin
						match_nx = (byte_s1 == NAME_UNDERSCORE) ? 2'd1 : 2'd0;
					end
				end
			end
			PH_PKG: begin
				if (byte_s1 == PACKAGE_OP) phase_nx = PH_LEAD;
			end
			PH_LEAD: begin
				len_nx   = byte_s1[7:6];
				phase_nx = (byte_s1[7:6] != 2'd0) ? PH_SKIP : PH_COUNT;
			end
			PH_SKIP: begin
				if (len_q <= 2'd1) begin
					len_nx   = 2'd0;
					phase_nx = PH_COUNT;
				end else begin
					len_nx = len_q - 1'b1;
				end
			end
			PH_COUNT: phase_nx = PH_A_START;
			PH_A_START: begin
				if (byte_s1 == BYTE_PREFIX && !last_s1) begin
					phase_nx = PH_A_BYTE;
				end else if (byte_s1 == WORD_PREFIX && !last_s1) begin
					phase_nx = PH_A_WLO;
				end else if (is_small) begin
					va_nx    = byte_s1[TYPE_BITS-1:0];
					phase_nx = PH_B_START;
				end else begin
					phase_nx = PH_DONE;
				end
			end
			PH_A_BYTE: begin
				va_nx    = byte_s1[TYPE_BITS-1:0];
				phase_nx = PH_B_START;
			end
			PH_A_WLO: begin
				if (last_s1) begin
					va_nx    = WORD_PREFIX[TYPE_BITS-1:0];
					vb_nx    = is_small ? byte_s1[TYPE_BITS-1:0] : '0;
					phase_nx = PH_DONE;
				end else begin
					hold_nx  = byte_s1[TYPE_BITS-1:0];
					phase_nx = PH_A_WHI;
				end
			end
			PH_A_WHI: begin
				va_nx    = hold_q;
				phase_nx = PH_B_START;
			end
			PH_B_START: begin
				if (byte_s1 == BYTE_PREFIX && !last_s1) begin
					phase_nx = PH_B_BYTE;
				end else begin
					if (is_small) vb_nx = byte_s1[TYPE_BITS-1:0];
					phase_nx = PH_DONE;
				end
			end
			PH_B_BYTE: begin
				vb_nx    = byte_s1[TYPE_BITS-1:0];
				phase_nx = PH_DONE;
			end
			default: ;
		endcase
	end

	always_comb begin
		if (cnt_nx < HdrCount || sum_nx != 8'd0) begin
			status_nx = ST_INVALID;
			a_nx      = '0;
			b_nx      = '0;
		end else if (phase_q == PH_LEAD || phase_nx == PH_NAME ||
				phase_nx == PH_PKG || phase_nx == PH_LEAD) begin
			status_nx = ST_DEFAULT;
			a_nx      = {{(TYPE_BITS-3){1'b0}}, dflt_q, {TYPE_SHIFT{1'b0}}};
			b_nx      = a_nx;
		end else if (phase_nx == PH_SKIP || phase_nx == PH_COUNT ||
				phase_nx == PH_A_START) begin
			status_nx = ST_TRUNC;
			a_nx      = '0;
			b_nx      = '0;
		end else begin
			status_nx = ST_PARSED;
			a_nx      = {va_nx, {TYPE_SHIFT{1'b0}}};
			b_nx      = {vb_nx, {TYPE_SHIFT{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_q      <= DEFAULT_TYPE_RST;
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			sum_q       <= '0;
			cnt_q       <= '0;
			phase_q     <= PH_NAME;
			match_q     <= '0;
			len_q       <= '0;
			va_q        <= '0;
			vb_q        <= '0;
			hold_q      <= '0;
		end else begin
			if (cfg.valid) dflt_q <= cfg.default_sleep_type;
			if (tbl.ready) valid_s1 <= tbl.valid;
			if (adv_s1 && last_s1) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			if (adv_s1) begin
				if (last_s1) begin
					// drop per-table state, hand the result over
					sum_q       <= '0;
					cnt_q       <= '0;
					phase_q     <= PH_NAME;
					match_q     <= '0;
					len_q       <= '0;
					va_q        <= '0;
					vb_q        <= '0;
					hold_q      <= '0;
				end else begin
					sum_q   <= sum_nx;
					cnt_q   <= cnt_nx;
					phase_q <= phase_nx;
					match_q <= match_nx;
					len_q   <= len_nx;
					va_q    <= va_nx;
					vb_q    <= vb_nx;
					hold_q  <= hold_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tbl.valid && tbl.ready) begin
			byte_s1 <= tbl.data_byte;
			last_s1 <= tbl.last;
		end
		if (adv_s1 && last_s1) begin
			res_status_q <= status_nx;
			res_a_q      <= a_nx;
			res_b_q      <= b_nx;
		end
	end

endmodule

// ===== src/s5scan_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S5 scanner checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module s5scan_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                res_valid,
	input logic                res_ready,
	input s5scan_pkg::status_t res_status,
	input logic [15:0]         res_a,
	input logic [15:0]         res_b
);
	import s5scan_pkg::*;

	// hold a stalled result
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_status) &&
			$stable(res_a) && $stable(res_b))
		else $error("result changed while stalled");

	a_low_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_a[TYPE_SHIFT-1:0] == '0 && res_b[TYPE_SHIFT-1:0] == '0)
		else $error("sleep type not shifted");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_status == ST_INVALID || res_status == ST_TRUNC)
			|-> res_a == 16'd0 && res_b == 16'd0)
		else $error("failed table with nonzero values");

	a_default_same: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == ST_DEFAULT
			|-> res_a == res_b && res_a[15:TYPE_SHIFT+3] == '0)
		else $error("default result malformed");

endmodule

bind acpi_s5_sleep_type_scanner s5scan_chk u_s5scan_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.res_status (res.status),
	.res_a      (res.sleep_type_a),
	.res_b      (res.sleep_type_b)
);
